>>> rtl/vmpc_pkg.sv
`timescale 1ns / 1ps

package vmpc_pkg;

  localparam int PosBits   = 16;
  localparam int ScaleBits = 25;
  localparam int ScaleSh   = 24;

  localparam logic [PosBits-1:0] StallTimeoutRst = PosBits'(500);
  localparam logic [PosBits-1:0] TravelCeilRst   = PosBits'(410);
  localparam logic [6:0]         PctFull         = 7'd100;

  // request codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_SENSOR = 3'd1;
  localparam logic [2:0] REQ_MOVE   = 3'd2;
  localparam logic [2:0] REQ_CAL    = 3'd3;
  localparam logic [2:0] REQ_BUTTON = 3'd4;

  // reported phase codes
  localparam logic [2:0] PH_CODE_IDLE      = 3'd0;
  localparam logic [2:0] PH_CODE_MOVE      = 3'd1;
  localparam logic [2:0] PH_CODE_PAUSE     = 3'd2;
  localparam logic [2:0] PH_CODE_CAL_OPEN  = 3'd3;
  localparam logic [2:0] PH_CODE_CAL_WAIT  = 3'd4;
  localparam logic [2:0] PH_CODE_CAL_CLOSE = 3'd5;

  typedef enum logic [5:0] {
    PH_IDLE      = 6'b000001,
    PH_MOVE      = 6'b000010,
    PH_PAUSE     = 6'b000100,
    PH_CAL_OPEN  = 6'b001000,
    PH_CAL_WAIT  = 6'b010000,
    PH_CAL_CLOSE = 6'b100000
  } phase_t;

  typedef enum logic [1:0] {
    DIR_STOP = 2'b00,
    DIR_UP   = 2'b01,
    DIR_DOWN = 2'b10
  } dir_t;

  typedef struct packed {
    logic drive_open;
    logic drive_close;
    logic sensor_power;
  } drive_t;

  typedef logic [ScaleBits-1:0] scale_tab_t [0:100];

  // ceil(pct * 2^24 / 100): target = (travel * scale) >> 24 is exact for 16 bit travel
  function automatic scale_tab_t build_scale();
    scale_tab_t tab;
    for (int i = 0; i <= 100; i++) begin
      tab[i] = ScaleBits'((longint'(i) * (longint'(1) << ScaleSh) + 99) / 100);
    end
    return tab;
  endfunction

  localparam scale_tab_t PctScale = build_scale();

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    unique case (ph)
      PH_IDLE:      code = PH_CODE_IDLE;
      PH_MOVE:      code = PH_CODE_MOVE;
      PH_PAUSE:     code = PH_CODE_PAUSE;
      PH_CAL_OPEN:  code = PH_CODE_CAL_OPEN;
      PH_CAL_WAIT:  code = PH_CODE_CAL_WAIT;
      PH_CAL_CLOSE: code = PH_CODE_CAL_CLOSE;
      default:      code = PH_CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

>>> rtl/valve_motor_position_controller.sv
`timescale 1ns / 1ps
// valve motor position controller
// input channel (in_valid / in_ready) carries one event per beat: req_type selects
// a millisecond tick, a sensor edge (sensor_level), a move command (percent),
// a calibration start or a button confirm
// output channel (out_valid / out_ready) returns one result beat per event: drive
// lines, position, travel, phase and the stop flags caused by that event
// the result is valid the cycle after the event is accepted
// throughput: one event per cycle while out_ready holds; the whole update is one pass of logic
// whose longest path is the 16 x 25 target scaling multiply and its compare
// in_ready is high while the result register is empty or being taken, so a
// stalled receiver holds the result and the state, and input beats wait
// reset (synchronous, rst high): counts cleared, motor off, phase idle,
// stall timeout 500 ticks, travel ceiling 410; no result pending
// apb port: 0x0 stall timeout, 0x4 travel ceiling, both 16 bit, pready tied high;
// write only while no event is in flight
module valve_motor_position_controller
  import vmpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // event channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic               sensor_level,
  input  logic [7:0]         percent,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               drive_open,
  output logic               drive_close,
  output logic               sensor_power,
  output logic [PosBits-1:0] position,
  output logic [PosBits-1:0] travel,
  output logic [2:0]         phase,
  output logic               stopped_by_stall,
  output logic               target_reached,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // configuration registers
  logic [PosBits-1:0] stall_timeout;
  logic [PosBits-1:0] travel_ceiling;

  // controller state
  logic [PosBits-1:0] position_count, position_count_next;
  logic [PosBits-1:0] target_count, target_count_next;
  logic [PosBits-1:0] travel_count, travel_count_next;
  logic [PosBits-1:0] idle_ticks, idle_ticks_next;
  dir_t               direction, direction_next;
  phase_t             phase_reg, phase_reg_next;
  drive_t             drive, drive_next;

  // per-beat flags and result valid
  logic stall_flag, stall_flag_next;
  logic reached_flag, reached_flag_next;
  logic res_valid;

  logic accept;

  // working values
  logic [PosBits:0]                 elapsed;
  logic [6:0]                       pct_sat;
  logic [PosBits+ScaleBits-1:0]     scaled;
  logic [PosBits-1:0]               move_target;

  assign pready   = 1'b1;
  assign in_ready = !res_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // apb write and read
  always_ff @(posedge clk) begin
    if (rst) begin
      stall_timeout  <= StallTimeoutRst;
      travel_ceiling <= TravelCeilRst;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        travel_ceiling <= pwdata[PosBits-1:0];
      end else begin
        stall_timeout <= pwdata[PosBits-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? {{(32-PosBits){1'b0}}, travel_ceiling}
                           : {{(32-PosBits){1'b0}}, stall_timeout};

  // percent to counts: saturate, then multiply by the scaled reciprocal of 100
  assign pct_sat     = (percent > 8'(PctFull)) ? PctFull : percent[6:0];
  assign scaled      = travel_count * PctScale[pct_sat];
  assign move_target = scaled[ScaleSh +: PosBits];

  assign elapsed = {1'b0, idle_ticks} + (PosBits+1)'(1);

  always_comb begin
    position_count_next = position_count;
    target_count_next   = target_count;
    travel_count_next   = travel_count;
    idle_ticks_next     = idle_ticks;
    direction_next      = direction;
    phase_reg_next      = phase_reg;
    drive_next          = drive;
    stall_flag_next     = 1'b0;
    reached_flag_next   = 1'b0;

    unique case (req_type)
      REQ_TICK: begin
        // saturating tick count since the last counted sensor edge or started run
        idle_ticks_next = elapsed[PosBits] ? '1 : elapsed[PosBits-1:0];
        unique case (phase_reg)
          PH_MOVE, PH_CAL_CLOSE: begin
            if (elapsed > {1'b0, stall_timeout}) begin
              direction_next  = DIR_STOP;
              drive_next      = '0;
              phase_reg_next  = PH_IDLE;
              stall_flag_next = 1'b1;
              if (phase_reg == PH_CAL_CLOSE) begin
                travel_count_next = position_count;
              end
            end
          end
          PH_CAL_OPEN: begin
            // fully open: this is the zero reference
            if (elapsed >= {1'b0, stall_timeout}) begin
              direction_next      = DIR_STOP;
              drive_next          = '0;
              position_count_next = '0;
              phase_reg_next      = PH_CAL_WAIT;
              stall_flag_next     = 1'b1;
            end
          end
          PH_PAUSE: begin
            // pause over: start towards the held target
            if (elapsed >= {1'b0, stall_timeout}) begin
              idle_ticks_next = '0;
              phase_reg_next  = PH_MOVE;
              if (target_count > position_count) begin
                direction_next = DIR_UP;
                drive_next     = '{drive_open: 1'b0, drive_close: 1'b1, sensor_power: 1'b1};
              end else begin
                direction_next = DIR_DOWN;
                drive_next     = '{drive_open: 1'b1, drive_close: 1'b0, sensor_power: 1'b1};
              end
            end
          end
          default: begin
          end
        endcase
      end

      REQ_SENSOR: begin
        if (direction != DIR_STOP) begin
          if (direction == DIR_UP && sensor_level) begin
            position_count_next = position_count + PosBits'(1);
            idle_ticks_next     = '0;
          end else if (direction == DIR_DOWN && !sensor_level) begin
            position_count_next = position_count - PosBits'(1);
            idle_ticks_next     = '0;
          end
          if ((phase_reg == PH_MOVE || phase_reg == PH_CAL_CLOSE) &&
              position_count_next == target_count) begin
            direction_next    = DIR_STOP;
            drive_next        = '0;
            phase_reg_next    = PH_IDLE;
            reached_flag_next = 1'b1;
            if (phase_reg == PH_CAL_CLOSE) begin
              travel_count_next = position_count_next;
            end
          end
        end
      end

      REQ_MOVE: begin
        if (phase_reg == PH_IDLE || phase_reg == PH_MOVE || phase_reg == PH_PAUSE) begin
          target_count_next = move_target;
          idle_ticks_next   = '0;
          if (phase_reg == PH_IDLE) begin
            phase_reg_next = PH_MOVE;
            if (move_target > position_count) begin
              direction_next = DIR_UP;
              drive_next     = '{drive_open: 1'b0, drive_close: 1'b1, sensor_power: 1'b1};
            end else begin
              direction_next = DIR_DOWN;
              drive_next     = '{drive_open: 1'b1, drive_close: 1'b0, sensor_power: 1'b1};
            end
          end else begin
            // running: let the motor coast for one timeout first
            phase_reg_next = PH_PAUSE;
            drive_next     = '{drive_open: 1'b0, drive_close: 1'b0, sensor_power: 1'b1};
          end
        end
      end

      REQ_CAL: begin
        if (phase_reg == PH_IDLE || phase_reg == PH_MOVE || phase_reg == PH_PAUSE) begin
          idle_ticks_next = '0;
          direction_next  = DIR_UP;
          drive_next      = '{drive_open: 1'b1, drive_close: 1'b0, sensor_power: 1'b1};
          phase_reg_next  = PH_CAL_OPEN;
        end
      end

      REQ_BUTTON: begin
        // closing run towards the ceiling; full scale target equals the travel
        if (phase_reg == PH_CAL_WAIT) begin
          travel_count_next = travel_ceiling;
          target_count_next = travel_ceiling;
          idle_ticks_next   = '0;
          phase_reg_next    = PH_CAL_CLOSE;
          if (travel_ceiling > position_count) begin
            direction_next = DIR_UP;
            drive_next     = '{drive_open: 1'b0, drive_close: 1'b1, sensor_power: 1'b1};
          end else begin
            direction_next = DIR_DOWN;
            drive_next     = '{drive_open: 1'b1, drive_close: 1'b0, sensor_power: 1'b1};
          end
        end
      end

      default: begin
      end
    endcase
  end

  // state only moves on an accepted beat, so the result ports read it directly
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      target_count   <= '0;
      travel_count   <= '0;
      idle_ticks     <= '0;
      direction      <= DIR_STOP;
      phase_reg      <= PH_IDLE;
      drive          <= '0;
      stall_flag     <= 1'b0;
      reached_flag   <= 1'b0;
      res_valid      <= 1'b0;
    end else begin
      if (accept) begin
        position_count <= position_count_next;
        target_count   <= target_count_next;
        travel_count   <= travel_count_next;
        idle_ticks     <= idle_ticks_next;
        direction      <= direction_next;
        phase_reg      <= phase_reg_next;
        drive          <= drive_next;
        stall_flag     <= stall_flag_next;
        reached_flag   <= reached_flag_next;
        res_valid      <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign out_valid        = res_valid;
  assign drive_open       = drive.drive_open;
  assign drive_close      = drive.drive_close;
  assign sensor_power     = drive.sensor_power;
  assign position         = position_count;
  assign travel           = travel_count;
  assign phase            = phase_code(phase_reg);
  assign stopped_by_stall = stall_flag;
  assign target_reached   = reached_flag;

endmodule
